/* hw/rtl/pdp_pkg.sv */
// shared types, constants and tables of the padding delay parser
package pdp_pkg;

    localparam int VALUE_BITS_DEF = 24;
    localparam int COUNT_BITS_DEF = 10;

    localparam int CHAR_W  = 8;
    localparam int CNT_W   = 10;
    localparam int TOTAL_W = 32;
    localparam int FRAC_W  = 4;
    localparam int DIV_W   = 50;

    localparam logic [FRAC_W-1:0] FRAC_MAX = 4'd15;

    localparam logic [CHAR_W-1:0] CH_DOLLAR = 8'h24;
    localparam logic [CHAR_W-1:0] CH_LT     = 8'h3C;
    localparam logic [CHAR_W-1:0] CH_POINT  = 8'h2E;
    localparam logic [CHAR_W-1:0] CH_STAR   = 8'h2A;
    localparam logic [CHAR_W-1:0] CH_GT     = 8'h3E;
    localparam logic [CHAR_W-1:0] CH_ZERO   = 8'h30;
    localparam logic [CHAR_W-1:0] CH_NINE   = 8'h39;
    localparam int                RADIX     = 10;

    typedef enum logic [1:0] {
        MODE_TEXT   = 2'd0,
        MODE_DOLLAR = 2'd1,
        MODE_MARK   = 2'd2
    } t_mode;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_DIV,
        ST_ADD,
        ST_EMIT
    } t_state;

    typedef struct packed {
        logic accept;
        logic mul;
        logic div_start;
        logic div_step;
        logic add;
        logic emit;
    } t_dp_cmd;

    typedef struct packed {
        logic term_req;
        logic last;
        logic need_div;
        logic div_done;
        logic out_free;
    } t_dp_status;

    function automatic logic [DIV_W-1:0] pow10(input logic [FRAC_W-1:0] idx);
        logic [DIV_W-1:0] res;
        unique case (idx)
            4'd0:    res = 50'd1;
            4'd1:    res = 50'd10;
            4'd2:    res = 50'd100;
            4'd3:    res = 50'd1000;
            4'd4:    res = 50'd10000;
            4'd5:    res = 50'd100000;
            4'd6:    res = 50'd1000000;
            4'd7:    res = 50'd10000000;
            4'd8:    res = 50'd100000000;
            4'd9:    res = 50'd1000000000;
            4'd10:   res = 50'd10000000000;
            4'd11:   res = 50'd100000000000;
            4'd12:   res = 50'd1000000000000;
            4'd13:   res = 50'd10000000000000;
            4'd14:   res = 50'd100000000000000;
            default: res = 50'd1000000000000000;
        endcase
        return res;
    endfunction

endpackage

/* hw/rtl/pdp_in_if.sv */
// input channel: one string byte per beat
interface pdp_in_if;
    logic                           valid;
    logic                           ready;
    logic [pdp_pkg::CHAR_W-1:0]     char_in;
    logic [pdp_pkg::CNT_W-1:0]      affected_count;
    logic                           last_char;

    modport source (output valid, char_in, affected_count, last_char, input ready);
    modport sink   (input valid, char_in, affected_count, last_char, output ready);
endinterface

/* hw/rtl/pdp_out_if.sv */
// output channel: one total delay per beat
interface pdp_out_if;
    logic                           valid;
    logic                           ready;
    logic [pdp_pkg::TOTAL_W-1:0]    total_delay;
    logic                           saturated;

    modport source (output valid, total_delay, saturated, input ready);
    modport sink   (input valid, total_delay, saturated, output ready);
endinterface

/* hw/rtl/pdp_ctrl.sv */
// controller state machine of the padding delay parser
module pdp_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  pdp_pkg::t_dp_status i_status,
    output pdp_pkg::t_dp_cmd    o_cmd
);

    pdp_pkg::t_state r_state, n_state;
    logic            r_last, n_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= pdp_pkg::ST_IDLE;
            r_last  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_last  <= n_last;
        end
    end

    always_comb begin
        n_state    = r_state;
        n_last     = r_last;
        o_in_ready = 1'b0;
        o_cmd      = '0;
        unique case (r_state)
            pdp_pkg::ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    n_last       = i_status.last;
                    if (i_status.term_req) begin
                        n_state = pdp_pkg::ST_MUL;
                    end else if (i_status.last) begin
                        n_state = pdp_pkg::ST_EMIT;
                    end
                end
            end
            pdp_pkg::ST_MUL: begin
                o_cmd.mul = 1'b1;
                if (i_status.need_div) begin
                    o_cmd.div_start = 1'b1;
                    n_state         = pdp_pkg::ST_DIV;
                end else begin
                    n_state = pdp_pkg::ST_ADD;
                end
            end
            pdp_pkg::ST_DIV: begin
                if (i_status.div_done) begin
                    n_state = pdp_pkg::ST_ADD;
                end else begin
                    o_cmd.div_step = 1'b1;
                end
            end
            pdp_pkg::ST_ADD: begin
                o_cmd.add = 1'b1;
                n_state   = r_last ? pdp_pkg::ST_EMIT : pdp_pkg::ST_IDLE;
            end
            pdp_pkg::ST_EMIT: begin
                if (i_status.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = pdp_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = pdp_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

/* hw/rtl/pdp_dpath.sv */
// datapath: parser registers, term multiplier, serial divider, total and output register
module pdp_dpath #(
    parameter int VALUE_BITS = pdp_pkg::VALUE_BITS_DEF,
    parameter int COUNT_BITS = pdp_pkg::COUNT_BITS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  pdp_pkg::t_dp_cmd             i_cmd,
    output pdp_pkg::t_dp_status          o_status,
    input  logic [pdp_pkg::CHAR_W-1:0]   i_char,
    input  logic [pdp_pkg::CNT_W-1:0]    i_count,
    input  logic                         i_last,
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output logic [pdp_pkg::TOTAL_W-1:0]  o_total,
    output logic                         o_sat
);

    localparam int PROD_W = VALUE_BITS + COUNT_BITS;
    localparam int SUM_W  = ((PROD_W > pdp_pkg::TOTAL_W) ? PROD_W : pdp_pkg::TOTAL_W) + 1;
    localparam int ITER_W = $clog2(PROD_W + 1);
    localparam int WIDE_W = 17;
    localparam int DIV_W  = pdp_pkg::DIV_W;
    localparam int FRAC_W = pdp_pkg::FRAC_W;

    localparam logic [WIDE_W-1:0] CNT_LIMIT = WIDE_W'((1 << COUNT_BITS) - 1);

    // parser state
    pdp_pkg::t_mode              r_mode, n_mode, p_mode;
    logic [VALUE_BITS-1:0]       r_value, n_value, p_value;
    logic                        r_point, n_point, p_point;
    logic [FRAC_W-1:0]           r_frac, n_frac, p_frac;
    logic [COUNT_BITS-1:0]       r_mult, n_mult, p_mult;
    logic [pdp_pkg::TOTAL_W-1:0] r_total, n_total;
    logic                        r_ovf, n_ovf, p_ovf;

    // term arithmetic
    logic [PROD_W-1:0]           r_prod, n_prod;
    logic [DIV_W-1:0]            r_rem, n_rem;
    logic [ITER_W-1:0]           r_iter, n_iter;

    // output register
    logic                        r_out_valid, n_out_valid;
    logic [pdp_pkg::TOTAL_W-1:0] r_out_total, n_out_total;
    logic                        r_out_sat, n_out_sat;

    logic [VALUE_BITS+3:0]       digit_acc;
    logic [WIDE_W-1:0]           cnt_wide;
    logic [DIV_W:0]              rem_sh;
    logic [DIV_W:0]              divisor;
    logic                        q_bit;
    logic [SUM_W-1:0]            sum;
    logic                        is_digit;

    // one byte of the parser
    always_comb begin
        p_mode    = r_mode;
        p_value   = r_value;
        p_point   = r_point;
        p_frac    = r_frac;
        p_mult    = r_mult;
        p_ovf     = r_ovf;
        is_digit  = (i_char >= pdp_pkg::CH_ZERO) && (i_char <= pdp_pkg::CH_NINE);
        digit_acc = ((VALUE_BITS+4)'(r_value) << 3) + ((VALUE_BITS+4)'(r_value) << 1)
                  + (VALUE_BITS+4)'(i_char[3:0]);
        cnt_wide  = WIDE_W'(i_count);
        case (r_mode)
            pdp_pkg::MODE_MARK: begin
                if (is_digit) begin
                    if (|digit_acc[VALUE_BITS+3:VALUE_BITS]) begin
                        p_value = {VALUE_BITS{1'b1}};
                        p_ovf   = 1'b1;
                    end else begin
                        p_value = digit_acc[VALUE_BITS-1:0];
                    end
                    if (r_point) begin
                        if (r_frac < pdp_pkg::FRAC_MAX) begin
                            p_frac = r_frac + 1'b1;
                        end else begin
                            p_ovf = 1'b1;
                        end
                    end
                end else if (i_char == pdp_pkg::CH_POINT) begin
                    p_point = 1'b1;
                    p_frac  = '0;
                end else if (i_char == pdp_pkg::CH_STAR) begin
                    p_mult = COUNT_BITS'((cnt_wide > CNT_LIMIT) ? CNT_LIMIT : cnt_wide);
                end else if (i_char == pdp_pkg::CH_GT) begin
                    p_mode = pdp_pkg::MODE_TEXT;
                end
            end
            pdp_pkg::MODE_DOLLAR: begin
                if (i_char == pdp_pkg::CH_LT) begin
                    p_mode  = pdp_pkg::MODE_MARK;
                    p_value = '0;
                    p_point = 1'b0;
                    p_frac  = '0;
                    p_mult  = COUNT_BITS'(1);
                end else if (i_char != pdp_pkg::CH_DOLLAR) begin
                    p_mode = pdp_pkg::MODE_TEXT;
                end
            end
            default: begin
                p_mode = (i_char == pdp_pkg::CH_DOLLAR) ? pdp_pkg::MODE_DOLLAR
                                                        : pdp_pkg::MODE_TEXT;
            end
        endcase
    end

    // restoring divider step and saturating add
    always_comb begin
        divisor = (DIV_W+1)'(pdp_pkg::pow10(r_frac));
        rem_sh  = {r_rem, r_prod[PROD_W-1]};
        q_bit   = (rem_sh >= divisor);
        sum     = SUM_W'(r_total) + SUM_W'(r_prod);
    end

    always_comb begin
        n_mode      = r_mode;
        n_value     = r_value;
        n_point     = r_point;
        n_frac      = r_frac;
        n_mult      = r_mult;
        n_total     = r_total;
        n_ovf       = r_ovf;
        n_prod      = r_prod;
        n_rem       = r_rem;
        n_iter      = r_iter;
        n_out_total = r_out_total;
        n_out_sat   = r_out_sat;
        n_out_valid = r_out_valid && !i_out_ready;

        if (i_cmd.accept) begin
            n_mode  = p_mode;
            n_value = p_value;
            n_point = p_point;
            n_frac  = p_frac;
            n_mult  = p_mult;
            n_ovf   = p_ovf;
        end
        if (i_cmd.mul) begin
            n_prod = PROD_W'(r_value) * PROD_W'(r_mult);
        end
        if (i_cmd.div_start) begin
            n_rem  = '0;
            n_iter = ITER_W'(PROD_W);
        end
        if (i_cmd.div_step) begin
            n_rem  = q_bit ? DIV_W'(rem_sh - divisor) : rem_sh[DIV_W-1:0];
            n_prod = {r_prod[PROD_W-2:0], q_bit};
            n_iter = r_iter - 1'b1;
        end
        if (i_cmd.add) begin
            if (|sum[SUM_W-1:pdp_pkg::TOTAL_W]) begin
                n_total = {pdp_pkg::TOTAL_W{1'b1}};
                n_ovf   = 1'b1;
            end else begin
                n_total = sum[pdp_pkg::TOTAL_W-1:0];
            end
        end
        if (i_cmd.emit) begin
            n_out_valid = 1'b1;
            n_out_total = r_total;
            n_out_sat   = r_ovf;
            n_mode      = pdp_pkg::MODE_TEXT;
            n_value     = '0;
            n_point     = 1'b0;
            n_frac      = '0;
            n_mult      = COUNT_BITS'(1);
            n_total     = '0;
            n_ovf       = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode      <= pdp_pkg::MODE_TEXT;
            r_value     <= '0;
            r_point     <= 1'b0;
            r_frac      <= '0;
            r_mult      <= COUNT_BITS'(1);
            r_total     <= '0;
            r_ovf       <= 1'b0;
            r_iter      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_mode      <= n_mode;
            r_value     <= n_value;
            r_point     <= n_point;
            r_frac      <= n_frac;
            r_mult      <= n_mult;
            r_total     <= n_total;
            r_ovf       <= n_ovf;
            r_iter      <= n_iter;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod      <= n_prod;
        r_rem       <= n_rem;
        r_out_total <= n_out_total;
        r_out_sat   <= n_out_sat;
    end

    assign o_status.term_req = ((r_mode == pdp_pkg::MODE_MARK) && (i_char == pdp_pkg::CH_GT))
                             || (i_last && (p_mode == pdp_pkg::MODE_MARK));
    assign o_status.last     = i_last;
    assign o_status.need_div = r_point && (r_frac != '0);
    assign o_status.div_done = (r_iter == '0);
    assign o_status.out_free = !r_out_valid || i_out_ready;

    assign o_out_valid = r_out_valid;
    assign o_total     = r_out_total;
    assign o_sat       = r_out_sat;

endmodule

/* hw/rtl/padding_delay_parser.sv */
// top level of the padding delay parser: sums the delay of "$<...>" markers in a string
//
// usage: i_in carries one byte of a capability string per beat with its affected
// count and a last-byte flag; o_out carries one beat per string with the summed
// delay in milliseconds and a saturation flag.
// flow: a new plain byte is accepted every clock while the controller is idle. a byte
// that closes a marker ('>' or the last byte inside one) then goes through multiply
// and add; with fraction digits the serial divider runs between the two (one
// quotient bit per cycle). the last byte then loads the result into o_out, waiting
// while o_out still holds an untaken result.
// o_out is a register: the next string is accepted while a result waits; only a
// second result blocks input until the first is taken.
// reset: synchronous, active low; clears the parser to plain text mode, the
// total to zero, the multiplier to one and drops any pending result.
module padding_delay_parser #(
    parameter int VALUE_BITS = pdp_pkg::VALUE_BITS_DEF,
    parameter int COUNT_BITS = pdp_pkg::COUNT_BITS_DEF
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    pdp_in_if.sink   i_in,
    pdp_out_if.source o_out
);

    // command and status between controller and datapath
    pdp_pkg::t_dp_cmd    cmd;
    pdp_pkg::t_dp_status status;

    // sequencer: accept, multiply, divide, add, emit
    pdp_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (i_in.ready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    // parser registers, term arithmetic and output beat register
    pdp_dpath #(
        .VALUE_BITS (VALUE_BITS),
        .COUNT_BITS (COUNT_BITS)
    ) u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_status    (status),
        .i_char      (i_in.char_in),
        .i_count     (i_in.affected_count),
        .i_last      (i_in.last_char),
        .o_out_valid (o_out.valid),
        .i_out_ready (o_out.ready),
        .o_total     (o_out.total_delay),
        .o_sat       (o_out.saturated)
    );

endmodule

/* test/pdp_checker.sv */
// checker for the padding delay parser: predicts each string's delay and compares it
module pdp_checker #(
    parameter int VALUE_BITS = pdp_pkg::VALUE_BITS_DEF,
    parameter int COUNT_BITS = pdp_pkg::COUNT_BITS_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    pdp_in_if    i_in,
    pdp_out_if   i_out,
    output int   o_fail_count,
    output int   o_pending
);
    import pdp_pkg::*;

    localparam logic [63:0] VALUE_TOP = (64'd1 << VALUE_BITS) - 64'd1;
    localparam logic [63:0] COUNT_TOP = (64'd1 << COUNT_BITS) - 64'd1;
    localparam logic [63:0] TOTAL_TOP = (64'd1 << TOTAL_W) - 64'd1;

    typedef struct packed {
        logic [TOTAL_W-1:0] total;
        logic               sat;
    } t_delay;

    t_delay            delay_q[$];
    int                fails;
    int                waiting;

    // predicted parser state
    t_mode             scan_st;
    logic [63:0]       value_acc;
    logic              point_flag;
    logic [FRAC_W-1:0] frac_cnt;
    logic [63:0]       mult_val;
    logic [63:0]       sum_acc;
    logic              sat_flag;

    assign o_fail_count = fails;
    assign o_pending    = waiting;

    function automatic logic [63:0] ten_pow(input int n);
        logic [63:0] p;
        p = 64'd1;
        repeat (n) p = p * RADIX;
        return p;
    endfunction

    task automatic start_marker();
        scan_st    = MODE_MARK;
        value_acc  = '0;
        point_flag = 1'b0;
        frac_cnt   = '0;
        mult_val   = 64'd1;
    endtask

    task automatic clear_string();
        start_marker();
        scan_st  = MODE_TEXT;
        sum_acc  = '0;
        sat_flag = 1'b0;
    endtask

    // close the open marker: value times multiplier, scaled down by the fraction digits
    task automatic fold_term();
        logic [63:0] term;
        logic [63:0] sum;
        term = value_acc * mult_val;
        if (point_flag && frac_cnt != '0) term = term / ten_pow(int'(frac_cnt));
        sum = sum_acc + term;
        if (sum > TOTAL_TOP) begin
            sum      = TOTAL_TOP;
            sat_flag = 1'b1;
        end
        sum_acc = sum;
    endtask

    task automatic parse_byte(input logic [CHAR_W-1:0] ch, input logic [CNT_W-1:0] cnt,
                              input logic last);
        logic [63:0] v;
        case (scan_st)
            MODE_MARK: begin
                if (ch >= CH_ZERO && ch <= CH_NINE) begin
                    v = value_acc * RADIX + 64'(ch - CH_ZERO);
                    if (v > VALUE_TOP) begin
                        v        = VALUE_TOP;
                        sat_flag = 1'b1;
                    end
                    value_acc = v;
                    if (point_flag) begin
                        if (frac_cnt < FRAC_MAX) frac_cnt = frac_cnt + 1'b1;
                        else sat_flag = 1'b1;
                    end
                end else if (ch == CH_POINT) begin
                    point_flag = 1'b1;
                    frac_cnt   = '0;
                end else if (ch == CH_STAR) begin
                    mult_val = (64'(cnt) > COUNT_TOP) ? COUNT_TOP : 64'(cnt);
                end else if (ch == CH_GT) begin
                    fold_term();
                    scan_st = MODE_TEXT;
                end
            end
            MODE_DOLLAR: begin
                if (ch == CH_LT) start_marker();
                else if (ch != CH_DOLLAR) scan_st = MODE_TEXT;
            end
            default: begin
                scan_st = (ch == CH_DOLLAR) ? MODE_DOLLAR : MODE_TEXT;
            end
        endcase
        if (last) begin
            if (scan_st == MODE_MARK) fold_term();
            delay_q.push_back('{total: sum_acc[TOTAL_W-1:0], sat: sat_flag});
            clear_string();
        end
    endtask

    initial begin
        fails   = 0;
        waiting = 0;
        clear_string();
    end

    always @(posedge i_clk) begin
        t_delay want;
        if (!i_rst_n) begin
            clear_string();
            delay_q.delete();
        end else begin
            if (i_out.valid && i_out.ready) begin
                if (delay_q.size() == 0) begin
                    $error("unexpected result: total_delay %0d saturated %0d",
                           i_out.total_delay, i_out.saturated);
                    fails++;
                end else begin
                    want = delay_q.pop_front();
                    if (i_out.total_delay !== want.total) begin
                        $error("total_delay mismatch: expected %0d, actual %0d",
                               want.total, i_out.total_delay);
                        fails++;
                    end
                    if (i_out.saturated !== want.sat) begin
                        $error("saturated mismatch: expected %0d, actual %0d",
                               want.sat, i_out.saturated);
                        fails++;
                    end
                end
            end
            if (i_in.valid && i_in.ready)
                parse_byte(i_in.char_in, i_in.affected_count, i_in.last_char);
        end
        waiting = delay_q.size();
    end

endmodule

/* test/tb.sv */
// testbench top: feeds capability strings to the padding delay parser and reports the verdict
module tb;
    import pdp_pkg::*;

    localparam int VALUE_BITS  = VALUE_BITS_DEF;
    localparam int COUNT_BITS  = COUNT_BITS_DEF;
    localparam int ITEM_TARGET = 1750;
    // quiet time after the drain, to watch for stray results
    localparam int TAIL_CYCLES = 64;
    // long output hold-off, so the result register fills and input backs up
    localparam int HOLD_AT     = 800;
    localparam int HOLD_LEN    = 400;

    typedef enum int {
        IDLE_NONE,
        IDLE_SEND,
        IDLE_RECV,
        IDLE_BOTH
    } t_idle;

    logic              i_clk;
    logic              i_rst_n;
    int                fail_cnt;
    int                pend_cnt;
    t_idle             idle_mode;
    int                sent_bytes;
    logic [CHAR_W-1:0] line_q[$];

    pdp_in_if  in_ch();
    pdp_out_if out_ch();

    padding_delay_parser #(
        .VALUE_BITS (VALUE_BITS),
        .COUNT_BITS (COUNT_BITS)
    ) u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    pdp_checker #(
        .VALUE_BITS (VALUE_BITS),
        .COUNT_BITS (COUNT_BITS)
    ) u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in         (in_ch),
        .i_out        (out_ch),
        .o_fail_count (fail_cnt),
        .o_pending    (pend_cnt)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // hard stop in case the block hangs
    initial begin
        #5000000;
        $display("padding_delay_parser test failed");
        $finish;
    end

    // per-cycle idle odds, in percent, for each side
    function automatic int send_idle_pct(input t_idle m);
        case (m)
            IDLE_SEND: return 47;
            IDLE_BOTH: return 38;
            default:   return 0;
        endcase
    endfunction

    function automatic int recv_idle_pct(input t_idle m);
        case (m)
            IDLE_RECV: return 47;
            IDLE_BOTH: return 38;
            default:   return 0;
        endcase
    endfunction

    // mostly small multipliers so totals stay in range, now and then the full field
    function automatic logic [CNT_W-1:0] pick_count();
        if ($urandom_range(0, 3) == 0) return CNT_W'($urandom_range(0, 2**CNT_W - 1));
        return CNT_W'($urandom_range(0, 15));
    endfunction

    // one beat on the input channel; an optional idle gap goes first
    task automatic send_byte(input logic [CHAR_W-1:0] ch, input logic [CNT_W-1:0] cnt,
                             input logic last);
        int pct;
        pct = send_idle_pct(idle_mode);
        if ($urandom_range(0, 99) < pct) begin
            in_ch.valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(0, 99) < pct);
        end
        in_ch.valid          <= 1'b1;
        in_ch.char_in        <= ch;
        in_ch.affected_count <= cnt;
        in_ch.last_char      <= last;
        do @(posedge i_clk); while (in_ch.ready !== 1'b1);
        sent_bytes++;
    endtask

    // a whole string with one fixed affected count on every byte
    task automatic send_text(input string s, input int cnt);
        for (int i = 0; i < s.len(); i++)
            send_byte(s[i], CNT_W'(cnt), i == s.len() - 1);
    endtask

    task automatic push_digits(input int n);
        repeat (n) line_q.push_back(CH_ZERO + CHAR_W'($urandom_range(0, 9)));
    endtask

    // digit run length: mostly short, sometimes long enough to clamp
    function automatic int int_digits();
        int r;
        r = $urandom_range(0, 99);
        if (r < 85) return $urandom_range(0, 4);
        if (r < 95) return $urandom_range(5, 8);
        return $urandom_range(9, 11);
    endfunction

    function automatic int frac_digits();
        int r;
        r = $urandom_range(0, 99);
        if (r < 80) return $urandom_range(0, 3);
        if (r < 92) return $urandom_range(4, 9);
        return $urandom_range(14, 18);
    endfunction

    // a "$<...>" marker with random content; sometimes broken or left open
    task automatic push_marker();
        repeat ($urandom_range(0, 3) == 0 ? $urandom_range(1, 2) : 0)
            line_q.push_back(CH_DOLLAR);
        line_q.push_back(CH_DOLLAR);
        line_q.push_back(CH_LT);
        push_digits(int_digits());
        if ($urandom_range(0, 1) == 1) begin
            line_q.push_back(CH_POINT);
            push_digits(frac_digits());
            // a repeated point restarts the fraction count
            if ($urandom_range(0, 9) == 0) begin
                line_q.push_back(CH_POINT);
                push_digits(frac_digits());
            end
        end
        if ($urandom_range(0, 2) == 0) line_q.push_back(CH_STAR);
        if ($urandom_range(0, 4) == 0) line_q.push_back(CHAR_W'($urandom_range(0, 255)));
        if ($urandom_range(0, 99) < 85) line_q.push_back(CH_GT);
    endtask

    // random string: plain text, stray dollars and markers in any order
    task automatic make_line();
        int segs;
        int kind;
        line_q.delete();
        segs = $urandom_range(1, 5);
        repeat (segs) begin
            kind = $urandom_range(0, 99);
            if (kind < 20) begin
                repeat ($urandom_range(1, 3))
                    line_q.push_back(CHAR_W'($urandom_range(0, 255)));
            end else if (kind < 28) begin
                line_q.push_back(CH_DOLLAR);
                line_q.push_back(CHAR_W'($urandom_range(0, 255)));
            end else begin
                push_marker();
            end
        end
    endtask

    // output side: random stalls per phase, plus one long hold-off
    initial begin
        int cyc;
        int hold_left;
        cyc       = 0;
        hold_left = 0;
        out_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (!i_rst_n) begin
                out_ch.ready <= 1'b0;
            end else begin
                cyc++;
                if (cyc == HOLD_AT) hold_left = HOLD_LEN;
                if (hold_left > 0) begin
                    hold_left--;
                    out_ch.ready <= 1'b0;
                end else begin
                    out_ch.ready <= ($urandom_range(0, 99) >= recv_idle_pct(idle_mode));
                end
            end
        end
    end

    // input side: reset, directed strings, random strings, drain, verdict
    initial begin
        int line_no;
        line_no    = 0;
        sent_bytes = 0;
        idle_mode  = IDLE_NONE;
        in_ch.valid          <= 1'b0;
        in_ch.char_in        <= '0;
        in_ch.affected_count <= '0;
        in_ch.last_char      <= 1'b0;
        i_rst_n              <= 1'b0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // zero byte as a whole string: nothing to add
        send_byte(8'h00, '0, 1'b1);
        // repeated dollar, stray byte in a marker, point with no digits, full multiplier
        send_text("$$<12a.*>", 2**CNT_W - 1);
        // repeated point restarts the fraction: 1275 * 4 / 100
        send_text("$<1.2.75*>", 4);
        // value and fraction count both clamp, string ends inside the marker
        send_text("$<.9999999999999999", 0);
        // one term beyond the 32-bit total
        send_text("$<5000000*", 2**CNT_W - 1);

        while (sent_bytes < ITEM_TARGET) begin
            // phases rotate every few strings, the first one without idling
            idle_mode = t_idle'((line_no / 6) % 4);
            make_line();
            foreach (line_q[i])
                send_byte(line_q[i], pick_count(), i == line_q.size() - 1);
            line_no++;
        end
        in_ch.valid <= 1'b0;

        // let the last push land, drain, then watch for strays
        @(posedge i_clk);
        wait (pend_cnt == 0);
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (fail_cnt == 0 && pend_cnt == 0) begin
            $display("padding_delay_parser test passed");
        end else begin
            $display("padding_delay_parser test failed");
        end
        $finish;
    end

endmodule
